// ----- hw/rtl/srd_pkg.sv -----
package srd_pkg;

   // Field widths fixed by the stream format
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int LEN_BITS           = 12;
   localparam int WIDTH_BITS         = 13;
   localparam int COLOR_BITS         = 8;
   localparam int BYTE_BITS          = 8;
   localparam int ACTION_BITS        = 2;
   localparam int PLAYER_BITS        = 3;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int CSR_DATA_BITS      = WIDTH_BITS;

   // Register reset values
   localparam logic [PLAYER_BITS-1:0] PLAYER_RESET = '0;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd4096;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PLAYER_INDEX = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd1;

   // Input actions
   localparam logic [ACTION_BITS-1:0] ACT_START_IMAGE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_START_ROW   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_STREAM_BYTE = 2'd2;

   // Command byte codes
   localparam logic [BYTE_BITS-1:0] CMD_SKIP_LONG   = 8'h03;
   localparam logic [BYTE_BITS-1:0] CMD_DISCARD_END = 8'h0f;
   localparam logic [1:0]           TAG_LIST        = 2'd0;
   localparam logic [1:0]           TAG_SKIP        = 2'd1;
   localparam logic [3:0]           LO_BIG_LIST     = 4'h2;
   localparam logic [3:0]           LO_PLAYER_LIST  = 4'h6;
   localparam logic [3:0]           LO_FILL         = 4'h7;
   localparam logic [3:0]           LO_PLAYER_FILL  = 4'ha;
   localparam logic [3:0]           LO_END_ROW      = 4'hf;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_COUNT,
      PH_COLOR,
      PH_LIST,
      PH_DISCARD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_PLAYER,
      KIND_SKIP,
      KIND_BIG
   } kind_type;

   typedef struct packed {
      logic uses_player;
      logic overflow;
      logic bad_command;
      logic end_of_row;
      logic transparent;
   } flags_type;

endpackage

// ----- hw/rtl/sprite_rle_row_decoder.sv -----
// Path: an accepted transaction is captured in the input register; its run loads the
// output register, which drives rsp_tvalid, once that register is free or draining.
// Throughput: one transaction per cycle while rsp_tready stays high; a stalled result
// lets one more transaction into the input register and then drops req_tready.
// Reset: synchronous, active high; clears both valid flags, the decoder state and the
// configuration registers (player 0, width 4096).
module sprite_rle_row_decoder #(
   parameter int COORD_BITS = srd_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((srd_pkg::BYTE_BITS + COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // req_tdata: data_byte, left_margin, zero fill
   input  logic [srd_pkg::ACTION_BITS-1:0]      req_tuser,
   // req_tuser: action
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((COORD_BITS + srd_pkg::LEN_BITS + srd_pkg::COLOR_BITS + 2 + 7) / 8) * 8
                 - 1:0]                         rsp_tdata,
   // rsp_tdata: run_x, run_length, run_color, overflow, uses_player, zero fill
   output logic [1:0]                           rsp_tuser,
   // rsp_tuser: transparent, bad_command
   output logic                                 rsp_tlast,
   // rsp_tlast: end_of_row
   // configuration port
   input  logic                                 csr_we,
   input  logic [srd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int RSP_PAY_W  = COORD_BITS + srd_pkg::LEN_BITS + srd_pkg::COLOR_BITS + 2;
   localparam int RSP_DATA_W = ((RSP_PAY_W + 7) / 8) * 8;

   logic                                  in_valid_ff, in_valid_in;
   logic [srd_pkg::ACTION_BITS-1:0]       in_action_ff;
   logic [srd_pkg::BYTE_BITS-1:0]         in_byte_ff;
   logic [COORD_BITS-1:0]                 in_margin_ff;

   logic [srd_pkg::PLAYER_BITS-1:0]       player_index_ff;
   logic [srd_pkg::WIDTH_BITS-1:0]        image_width_ff;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]                 rsp_x_ff;
   logic [srd_pkg::LEN_BITS-1:0]          rsp_len_ff;
   logic [srd_pkg::COLOR_BITS-1:0]        rsp_color_ff;
   srd_pkg::flags_type                    rsp_flags_ff;

   logic                                  req_fire;
   logic                                  step;
   logic                                  res_valid;
   logic [COORD_BITS-1:0]                 res_x;
   logic [srd_pkg::LEN_BITS-1:0]          res_length;
   logic [srd_pkg::COLOR_BITS-1:0]        res_color;
   srd_pkg::flags_type                    res_flags;

   // Handshake: decode when the output register is free or draining
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_fire   = req_tvalid && req_tready;

   // Input register
   assign in_valid_in = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata[srd_pkg::BYTE_BITS-1:0];
         in_margin_ff <= req_tdata[srd_pkg::BYTE_BITS +: COORD_BITS];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         player_index_ff <= srd_pkg::PLAYER_RESET;
         image_width_ff  <= srd_pkg::WIDTH_RESET;
      end else if (csr_we) begin
         if (csr_index == srd_pkg::REG_PLAYER_INDEX) begin
            player_index_ff <= csr_wdata[srd_pkg::PLAYER_BITS-1:0];
         end
         if (csr_index == srd_pkg::REG_IMAGE_WIDTH) begin
            image_width_ff <= csr_wdata[srd_pkg::WIDTH_BITS-1:0];
         end
      end
   end

   srd_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .action       (in_action_ff),
      .data_byte    (in_byte_ff),
      .left_margin  (in_margin_ff),
      .player_index (player_index_ff),
      .image_width  (image_width_ff),
      .res_valid    (res_valid),
      .res_x        (res_x),
      .res_length   (res_length),
      .res_color    (res_color),
      .res_flags    (res_flags)
   );

   // Output register: load a new run, drop a taken one
   assign rsp_valid_in = step ? res_valid : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_x_ff     <= res_x;
         rsp_len_ff   <= res_length;
         rsp_color_ff <= res_color;
         rsp_flags_ff <= res_flags;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_flags_ff.uses_player, rsp_flags_ff.overflow,
                                    rsp_color_ff, rsp_len_ff, rsp_x_ff});
   assign rsp_tuser  = {rsp_flags_ff.bad_command, rsp_flags_ff.transparent};
   assign rsp_tlast  = rsp_flags_ff.end_of_row;

`ifndef SYNTHESIS
   // A stalled result is never replaced by a new decode
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !step)
      else $error("output register overwritten while stalled");

   // An accepted transaction occupies the input register on the next cycle
   a_in_loaded: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted transaction lost");

   // Row end and error markers carry no pixels
   a_marker_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_flags_ff.end_of_row || rsp_flags_ff.bad_command)
      |-> rsp_len_ff == '0 && !rsp_flags_ff.overflow && !rsp_flags_ff.transparent)
      else $error("marker result carries a run");

   // Skips are colourless and never empty
   a_skip_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.transparent
      |-> rsp_color_ff == '0 && rsp_len_ff != '0)
      else $error("malformed transparent run");
`endif

endmodule

// ----- hw/rtl/srd_core.sv -----
module srd_core #(
   parameter int COORD_BITS = srd_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [srd_pkg::ACTION_BITS-1:0]     action,
   input  logic [srd_pkg::BYTE_BITS-1:0]       data_byte,
   input  logic [COORD_BITS-1:0]               left_margin,
   input  logic [srd_pkg::PLAYER_BITS-1:0]     player_index,
   input  logic [srd_pkg::WIDTH_BITS-1:0]      image_width,
   output logic                                res_valid,
   output logic [COORD_BITS-1:0]               res_x,
   output logic [srd_pkg::LEN_BITS-1:0]        res_length,
   output logic [srd_pkg::COLOR_BITS-1:0]      res_color,
   output srd_pkg::flags_type                  res_flags
);

   localparam int XW    = COORD_BITS + 1;
   localparam int SUM_W = ((XW > srd_pkg::WIDTH_BITS) ? XW : srd_pkg::WIDTH_BITS) + 1;

   srd_pkg::phase_type                 phase_ff, phase_in;
   srd_pkg::kind_type                  kind_ff, kind_in;
   logic [srd_pkg::LEN_BITS-1:0]       remaining_ff, remaining_in;
   logic [3:0]                         count_high_ff, count_high_in;
   logic [XW-1:0]                      x_pos_ff, x_pos_in;
   logic                               player_used_ff, player_used_in;

   logic                               emit_en;
   logic [srd_pkg::LEN_BITS-1:0]       emit_len;
   logic [srd_pkg::COLOR_BITS-1:0]     emit_color;
   logic                               emit_transp;
   logic                               emit_eor;
   logic                               emit_bad;

   logic [3:0]                         lo;
   logic [3:0]                         hi;
   logic [3:0]                         band;
   logic [srd_pkg::COLOR_BITS-1:0]     tint;
   logic [srd_pkg::COLOR_BITS-1:0]     pick_color;
   logic [srd_pkg::LEN_BITS-1:0]       rem_dec;
   logic [srd_pkg::LEN_BITS-1:0]       big_count;
   logic [SUM_W-1:0]                   x_sum;
   logic [XW-1:0]                      x_sat;

   // Byte fields and player colour band
   assign lo         = data_byte[3:0];
   assign hi         = data_byte[7:4];
   assign band       = 4'(player_index) + 4'd1;
   assign tint       = data_byte + {band, 4'b0000};
   assign pick_color = (kind_ff == srd_pkg::KIND_PLAYER) ? tint : data_byte;
   assign rem_dec    = remaining_ff - srd_pkg::LEN_BITS'(1);
   assign big_count  = {count_high_ff, data_byte};

   // Decode one transaction: next state and the run it draws
   always_comb begin
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      remaining_in   = remaining_ff;
      count_high_in  = count_high_ff;
      player_used_in = player_used_ff;
      emit_en        = 1'b0;
      emit_len       = '0;
      emit_color     = '0;
      emit_transp    = 1'b0;
      emit_eor       = 1'b0;
      emit_bad       = 1'b0;
      if (step) begin
         if (action == srd_pkg::ACT_START_IMAGE) begin
            phase_in       = srd_pkg::PH_IDLE;
            kind_in        = srd_pkg::KIND_PLAIN;
            remaining_in   = '0;
            count_high_in  = '0;
            player_used_in = 1'b0;
         end else if (action == srd_pkg::ACT_START_ROW) begin
            phase_in     = srd_pkg::PH_IDLE;
            remaining_in = '0;
         end else if (action == srd_pkg::ACT_STREAM_BYTE) begin
            case (phase_ff)
               srd_pkg::PH_COUNT: begin
                  if (kind_ff == srd_pkg::KIND_SKIP) begin
                     phase_in = srd_pkg::PH_IDLE;
                     if (data_byte != '0) begin
                        emit_en     = 1'b1;
                        emit_len    = srd_pkg::LEN_BITS'(data_byte);
                        emit_transp = 1'b1;
                     end
                  end else if (kind_ff == srd_pkg::KIND_BIG) begin
                     remaining_in = big_count;
                     kind_in      = srd_pkg::KIND_PLAIN;
                     phase_in     = (big_count != '0) ? srd_pkg::PH_LIST : srd_pkg::PH_IDLE;
                  end else begin
                     remaining_in = srd_pkg::LEN_BITS'(data_byte);
                     phase_in     = srd_pkg::PH_COLOR;
                  end
               end
               srd_pkg::PH_COLOR: begin
                  phase_in = srd_pkg::PH_IDLE;
                  if (remaining_ff != '0) begin
                     emit_en    = 1'b1;
                     emit_len   = remaining_ff;
                     emit_color = pick_color;
                  end
               end
               srd_pkg::PH_LIST: begin
                  emit_en      = 1'b1;
                  emit_len     = srd_pkg::LEN_BITS'(1);
                  emit_color   = pick_color;
                  remaining_in = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in = srd_pkg::PH_IDLE;
                  end
               end
               srd_pkg::PH_DISCARD: begin
                  if (data_byte == srd_pkg::CMD_DISCARD_END) begin
                     phase_in = srd_pkg::PH_IDLE;
                  end
               end
               default: begin
                  // idle: this byte is a command
                  phase_in = srd_pkg::PH_IDLE;
                  if (data_byte == srd_pkg::CMD_SKIP_LONG) begin
                     kind_in  = srd_pkg::KIND_SKIP;
                     phase_in = srd_pkg::PH_COUNT;
                  end else if (data_byte[1:0] == srd_pkg::TAG_LIST && data_byte != '0) begin
                     remaining_in = srd_pkg::LEN_BITS'(data_byte[7:2]);
                     kind_in      = srd_pkg::KIND_PLAIN;
                     phase_in     = srd_pkg::PH_LIST;
                  end else if (data_byte[1:0] == srd_pkg::TAG_SKIP
                               && data_byte != srd_pkg::BYTE_BITS'(1)) begin
                     emit_en     = 1'b1;
                     emit_len    = srd_pkg::LEN_BITS'(data_byte[7:2]);
                     emit_transp = 1'b1;
                  end else if (lo == srd_pkg::LO_BIG_LIST) begin
                     count_high_in = hi;
                     kind_in       = srd_pkg::KIND_BIG;
                     phase_in      = srd_pkg::PH_COUNT;
                  end else if (lo == srd_pkg::LO_PLAYER_LIST && hi != '0) begin
                     player_used_in = 1'b1;
                     remaining_in   = srd_pkg::LEN_BITS'(hi);
                     kind_in        = srd_pkg::KIND_PLAYER;
                     phase_in       = srd_pkg::PH_LIST;
                  end else if (lo == srd_pkg::LO_FILL || lo == srd_pkg::LO_PLAYER_FILL) begin
                     if (lo == srd_pkg::LO_PLAYER_FILL) begin
                        kind_in        = srd_pkg::KIND_PLAYER;
                        player_used_in = 1'b1;
                     end else begin
                        kind_in = srd_pkg::KIND_PLAIN;
                     end
                     remaining_in = srd_pkg::LEN_BITS'(hi);
                     phase_in     = (hi != '0) ? srd_pkg::PH_COLOR : srd_pkg::PH_COUNT;
                  end else if (lo == srd_pkg::LO_END_ROW) begin
                     emit_en  = 1'b1;
                     emit_eor = 1'b1;
                  end else begin
                     phase_in = srd_pkg::PH_DISCARD;
                     emit_en  = 1'b1;
                     emit_bad = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Advance x past the run, saturating
   assign x_sum = SUM_W'(x_pos_ff) + SUM_W'(emit_len);
   assign x_sat = (|x_sum[SUM_W-1:XW]) ? '1 : x_sum[XW-1:0];

   always_comb begin
      x_pos_in = x_pos_ff;
      if (step && action == srd_pkg::ACT_START_IMAGE) begin
         x_pos_in = '0;
      end else if (step && action == srd_pkg::ACT_START_ROW) begin
         x_pos_in = XW'(left_margin);
      end else if (emit_en) begin
         x_pos_in = x_sat;
      end
   end

   // Result fields
   assign res_valid               = emit_en;
   assign res_x                   = x_pos_ff[COORD_BITS] ? '1 : x_pos_ff[COORD_BITS-1:0];
   assign res_length              = emit_len;
   assign res_color               = emit_color;
   assign res_flags.transparent   = emit_transp;
   assign res_flags.end_of_row    = emit_eor;
   assign res_flags.bad_command   = emit_bad;
   assign res_flags.overflow      = (emit_len != '0) && (x_sum > SUM_W'(image_width));
   assign res_flags.uses_player   = player_used_ff;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= srd_pkg::PH_IDLE;
         kind_ff        <= srd_pkg::KIND_PLAIN;
         remaining_ff   <= '0;
         count_high_ff  <= '0;
         x_pos_ff       <= '0;
         player_used_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         kind_ff        <= kind_in;
         remaining_ff   <= remaining_in;
         count_high_ff  <= count_high_in;
         x_pos_ff       <= x_pos_in;
         player_used_ff <= player_used_in;
      end
   end

endmodule
